FILE: rtl/core/pfsa_pkg.sv
// pfsa_pkg: shared constants, types and state codes of the page frame stack allocator
// used by every file under rtl/core; has no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pfsa_pkg;

	localparam int STACK_DEPTH = 4096;
	localparam int PAGE_SHIFT = 12;

	localparam int ADDR_W = 32;
	localparam int FRAME_W = ADDR_W - PAGE_SHIFT;
	localparam int RAM_AW = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (FRAME_W > CNT_W) ? FRAME_W : CNT_W;
	localparam int OUT_CNT_W = 13;
	localparam int STATUS_W = 2;

	localparam logic KIND_FREE = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CLAMP,
		ST_PUSH,
		ST_READ,
		ST_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic we;
		logic [RAM_AW-1:0] waddr;
		logic [FRAME_W-1:0] wdata;
		logic re;
		logic [RAM_AW-1:0] raddr;
	} ram_req_t;

endpackage
`default_nettype wire

FILE: rtl/core/pfsa_if.sv
// pfsa_if: valid/ready channel interfaces for commands and responses
// depends on pfsa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none
interface pfsa_cmd_if;
	logic valid;
	logic ready;
	logic kind;
	logic [pfsa_pkg::ADDR_W-1:0] region_base;
	logic [pfsa_pkg::ADDR_W-1:0] region_len;

	modport source (output valid, output kind, output region_base, output region_len,
		input ready);
	modport sink (input valid, input kind, input region_base, input region_len,
		output ready);
endinterface

interface pfsa_res_if;
	logic valid;
	logic ready;
	logic [pfsa_pkg::ADDR_W-1:0] page_addr;
	logic [pfsa_pkg::STATUS_W-1:0] status;
	logic [pfsa_pkg::OUT_CNT_W-1:0] pages_pushed;
	logic [pfsa_pkg::OUT_CNT_W-1:0] free_count;

	modport source (output valid, output page_addr, output status, output pages_pushed,
		output free_count, input ready);
	modport sink (input valid, input page_addr, input status, input pages_pushed,
		input free_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/page_frame_stack_allocator_top.sv
// page_frame_stack_allocator_top: free page frame stack allocator top level
// depends on pfsa_pkg, pfsa_if, pfsa_stack_ram and pfsa_seq
//
// commands arrive on cmd: kind 0 frees a region (region_base, region_len in bytes),
// kind 1 allocates one page; every command gives exactly one transfer on res
// a free aligns the base up to a page boundary, cuts the rest to whole pages and
// pushes them in ascending order, one page per cycle, until done or the stack fills
// cmd is taken one command at a time; ready is high only while the sequencer is idle
// allocate: the command steps through READ, WAIT (skipped on an empty stack) and DONE
// free: PREP, CLAMP, the push loop through the one write port (if any page fits), DONE;
// the result is registered in DONE, and the next command can be taken in the cycle
// after the result is loaded, so a new command waits until the last one is through
// the result waits in an output register; while res is stalled the sequencer holds
// in its final step and takes no new command until the result register frees up
// reset empties the stack at once; stack contents need no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module page_frame_stack_allocator_top (
	input wire logic clk,
	input wire logic arst_n,
	pfsa_cmd_if.sink cmd,
	pfsa_res_if.source res
);

	pfsa_pkg::ram_req_t ram_req;
	logic [pfsa_pkg::FRAME_W-1:0] ram_rdata;

	pfsa_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.res(res),
		.ram_req(ram_req),
		.ram_rdata(ram_rdata)
	);

	pfsa_stack_ram u_ram (
		.clk(clk),
		.req(ram_req),
		.rdata(ram_rdata)
	);

endmodule
`default_nettype wire

FILE: rtl/core/pfsa_stack_ram.sv
// pfsa_stack_ram: frame number store, one write and one registered read per cycle
// depends on pfsa_pkg for depth, widths and the request struct
`timescale 1ns / 1ps
`default_nettype none
module pfsa_stack_ram (
	input wire logic clk,
	input wire pfsa_pkg::ram_req_t req,
	output logic [pfsa_pkg::FRAME_W-1:0] rdata
);

	logic [pfsa_pkg::FRAME_W-1:0] mem_q [pfsa_pkg::STACK_DEPTH];
	logic [pfsa_pkg::FRAME_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/core/pfsa_seq.sv
// pfsa_seq: sequencer and shared datapath for region frees and page allocations
// depends on pfsa_pkg and the channel interfaces in pfsa_if
`timescale 1ns / 1ps
`default_nettype none
module pfsa_seq (
	input wire logic clk,
	input wire logic arst_n,
	pfsa_cmd_if.sink cmd,
	pfsa_res_if.source res,
	output pfsa_pkg::ram_req_t ram_req,
	input wire logic [pfsa_pkg::FRAME_W-1:0] ram_rdata
);

	localparam int PS = pfsa_pkg::PAGE_SHIFT;
	localparam int FW = pfsa_pkg::FRAME_W;
	localparam int CW = pfsa_pkg::CNT_W;
	localparam int MW = pfsa_pkg::CMP_W;
	localparam int AW = pfsa_pkg::ADDR_W;
	localparam int OW = pfsa_pkg::OUT_CNT_W;

	pfsa_pkg::state_t state_q, state_d;

	logic kind_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] len_q;
	logic fits_q;
	logic [FW-1:0] pages_q;
	logic [FW-1:0] pfn_q;
	logic [CW-1:0] sp_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pushed_q;
	logic [pfsa_pkg::STATUS_W-1:0] status_q;
	logic [AW-1:0] addr_q;

	logic res_valid_q;
	logic [AW-1:0] res_addr_q;
	logic [pfsa_pkg::STATUS_W-1:0] res_status_q;
	logic [OW-1:0] res_pushed_q;
	logic [OW-1:0] res_count_q;

	logic cmd_fire;
	logic res_load;
	logic [PS-1:0] gap;
	logic [AW:0] rem;
	logic [CW-1:0] room;
	logic over;
	logic [CW-1:0] sp_dec;

	assign cmd_fire = cmd.valid && cmd.ready;
	assign res_load = (state_q == pfsa_pkg::ST_DONE) && (!res_valid_q || res.ready);

	// distance up to the next page boundary and the length left after it
	assign gap = PS'(0) - base_q[PS-1:0];
	assign rem = {1'b0, len_q} - {{(AW + 1 - PS){1'b0}}, gap};
	assign room = CW'(pfsa_pkg::STACK_DEPTH) - sp_q;
	assign over = MW'(pages_q) > MW'(room);
	assign sp_dec = sp_q - CW'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfsa_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					state_d = (cmd.kind == pfsa_pkg::KIND_ALLOC) ? pfsa_pkg::ST_READ
						: pfsa_pkg::ST_PREP;
				end
			end
			pfsa_pkg::ST_PREP: state_d = pfsa_pkg::ST_CLAMP;
			pfsa_pkg::ST_CLAMP: begin
				if (!fits_q || pages_q == '0 || room == '0) begin
					state_d = pfsa_pkg::ST_DONE;
				end else begin
					state_d = pfsa_pkg::ST_PUSH;
				end
			end
			pfsa_pkg::ST_PUSH: begin
				if (cnt_q == CW'(1)) begin
					state_d = pfsa_pkg::ST_DONE;
				end
			end
			pfsa_pkg::ST_READ: begin
				state_d = (sp_q == '0) ? pfsa_pkg::ST_DONE : pfsa_pkg::ST_WAIT;
			end
			pfsa_pkg::ST_WAIT: state_d = pfsa_pkg::ST_DONE;
			pfsa_pkg::ST_DONE: begin
				if (res_load) begin
					state_d = pfsa_pkg::ST_IDLE;
				end
			end
			default: state_d = pfsa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = 1'b0;
		ram_req.we = 1'b0;
		ram_req.waddr = sp_q[pfsa_pkg::RAM_AW-1:0];
		ram_req.wdata = pfn_q;
		ram_req.re = 1'b0;
		ram_req.raddr = sp_dec[pfsa_pkg::RAM_AW-1:0];
		unique case (state_q)
			pfsa_pkg::ST_IDLE: cmd.ready = 1'b1;
			pfsa_pkg::ST_PUSH: ram_req.we = 1'b1;
			pfsa_pkg::ST_READ: ram_req.re = (sp_q != '0);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfsa_pkg::ST_IDLE;
			sp_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == pfsa_pkg::ST_PUSH) begin
				sp_q <= sp_q + CW'(1);
			end else if (state_q == pfsa_pkg::ST_READ && sp_q != '0) begin
				sp_q <= sp_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pfsa_pkg::ST_IDLE: begin
				kind_q <= cmd.kind;
				base_q <= cmd.region_base;
				len_q <= cmd.region_len;
				status_q <= pfsa_pkg::STATUS_OK;
				addr_q <= '0;
				pushed_q <= '0;
			end
			pfsa_pkg::ST_PREP: begin
				fits_q <= !rem[AW];
				pages_q <= rem[AW-1:PS];
				pfn_q <= base_q[AW-1:PS] + FW'(base_q[PS-1:0] != '0);
			end
			pfsa_pkg::ST_CLAMP: begin
				if (fits_q) begin
					if (over) begin
						cnt_q <= room;
						pushed_q <= room;
						if (pages_q != '0) begin
							status_q <= pfsa_pkg::STATUS_FULL;
						end
					end else begin
						cnt_q <= CW'(pages_q);
						pushed_q <= CW'(pages_q);
					end
				end
			end
			pfsa_pkg::ST_PUSH: begin
				pfn_q <= pfn_q + FW'(1);
				cnt_q <= cnt_q - CW'(1);
			end
			pfsa_pkg::ST_READ: begin
				if (sp_q == '0) begin
					status_q <= pfsa_pkg::STATUS_EMPTY;
				end
			end
			pfsa_pkg::ST_WAIT: addr_q <= {ram_rdata, {PS{1'b0}}};
			pfsa_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
		if (res_load) begin
			res_addr_q <= (kind_q == pfsa_pkg::KIND_ALLOC) ? addr_q : '0;
			res_status_q <= status_q;
			res_pushed_q <= OW'(pushed_q);
			res_count_q <= OW'(sp_q);
		end
	end

	assign res.valid = res_valid_q;
	assign res.page_addr = res_addr_q;
	assign res.status = res_status_q;
	assign res.pages_pushed = res_pushed_q;
	assign res.free_count = res_count_q;

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// tb_top: self-checking bench for page_frame_stack_allocator_top
// holds a frame stack predictor, a directed table and three random phases of bursts and noise
// depends on pfsa_pkg, pfsa_if and the allocator rtl
`timescale 1ns / 1ps
module tb_top;
	import pfsa_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 6;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int END_CYCLES = 24;
	localparam int STALL_LIMIT = 20000;
	localparam int DIR_ROWS = 19;
	localparam logic [ADDR_W-1:0] PAGE_BYTES = 32'd1 << PAGE_SHIFT;
	localparam logic [ADDR_W-1:0] OFFSET_MASK = PAGE_BYTES - 32'd1;

	typedef struct packed {
		logic kind;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] len;
	} pfsa_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] page_addr;
		logic [STATUS_W-1:0] status;
		logic [OUT_CNT_W-1:0] pages_pushed;
		logic [OUT_CNT_W-1:0] free_count;
	} pfsa_result_t;

	typedef struct packed {
		pfsa_cmd_t cmd;
		logic typed;
		pfsa_result_t want;
	} dir_row_t;

	typedef struct packed {
		pfsa_result_t pred;
		logic typed;
		pfsa_result_t want;
	} pending_t;

	typedef enum int {
		NOISE_ALLOC,
		NOISE_SHORT,
		NOISE_NO_PAGE,
		NOISE_ONE_PAGE
	} noise_t;

	logic clk;
	logic arst_n;

	pfsa_cmd_if cmd_if ();
	pfsa_res_if res_if ();

	page_frame_stack_allocator_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if)
	);

	// predictor state
	logic [FRAME_W-1:0] frame_stack [STACK_DEPTH];
	int unsigned free_pages = 0;

	pending_t pending_results [$];
	pending_t head;
	pfsa_result_t got;
	pfsa_result_t pred_now;

	int fail_count = 0;
	int n_alloc = 0;
	int n_free = 0;
	int n_empty = 0;
	int n_full = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit hold_pending = 1'b0;
	int stall_cycles = 0;

	logic row_typed = 1'b0;
	pfsa_result_t row_want = '0;

	// expected results, oldest first: page, code, pushed, count
	dir_row_t dir_tbl [DIR_ROWS] = '{
		'{'{KIND_ALLOC, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{32'h0000_0000, STATUS_EMPTY, 13'd0, 13'd0}},
		'{'{KIND_FREE, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{32'h0000_0000, STATUS_OK, 13'd0, 13'd0}},
		'{'{KIND_FREE, 32'h0000_0001, 32'h0000_0FFE}, 1'b1,
			'{32'h0000_0000, STATUS_OK, 13'd0, 13'd0}},
		'{'{KIND_FREE, 32'h0000_0001, 32'h0000_1FFF}, 1'b1,
			'{32'h0000_0000, STATUS_OK, 13'd1, 13'd1}},
		'{'{KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{32'h0000_1000, STATUS_OK, 13'd0, 13'd0}},
		'{'{KIND_FREE, 32'hFFFF_F000, 32'h0000_3000}, 1'b1,
			'{32'h0000_0000, STATUS_OK, 13'd3, 13'd3}},
		'{'{KIND_ALLOC, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{32'h0000_1000, STATUS_OK, 13'd0, 13'd2}},
		'{'{KIND_ALLOC, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{32'h0000_0000, STATUS_OK, 13'd0, 13'd1}},
		'{'{KIND_ALLOC, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{32'hFFFF_F000, STATUS_OK, 13'd0, 13'd0}},
		'{'{KIND_ALLOC, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{32'h0000_0000, STATUS_EMPTY, 13'd0, 13'd0}},
		'{'{KIND_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{32'h0000_0000, STATUS_FULL, 13'd4096, 13'd4096}},
		'{'{KIND_FREE, 32'h0000_0000, 32'h0000_1000}, 1'b1,
			'{32'h0000_0000, STATUS_FULL, 13'd0, 13'd4096}},
		'{'{KIND_FREE, 32'h0000_0000, 32'h0000_0FFF}, 1'b1,
			'{32'h0000_0000, STATUS_OK, 13'd0, 13'd4096}},
		'{'{KIND_ALLOC, 32'h0000_0000, 32'h0000_0000}, 1'b1,
			'{32'h00FF_F000, STATUS_OK, 13'd0, 13'd4095}},
		'{'{KIND_FREE, 32'h0001_2345, 32'h0000_5000}, 1'b0, '0},
		'{'{KIND_ALLOC, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
		'{'{KIND_FREE, 32'h0000_0800, 32'h0000_0800}, 1'b1,
			'{32'h0000_0000, STATUS_OK, 13'd0, 13'd4095}},
		'{'{KIND_FREE, 32'hABCD_E000, 32'h0000_1000}, 1'b1,
			'{32'h0000_0000, STATUS_OK, 13'd1, 13'd4096}},
		'{'{KIND_ALLOC, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b1,
			'{32'hABCD_E000, STATUS_OK, 13'd0, 13'd4095}}
	};

	function automatic pfsa_result_t next_frame_result(input pfsa_cmd_t c);
		pfsa_result_t r;
		logic [ADDR_W-1:0] gap;
		logic [FRAME_W-1:0] frame;
		int unsigned pages;
		int unsigned room;
		int unsigned n;
		r = '0;
		if (c.kind == KIND_ALLOC) begin
			if (free_pages == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				free_pages--;
				r.page_addr = {frame_stack[free_pages], {PAGE_SHIFT{1'b0}}};
			end
		end else begin
			gap = (32'h0 - c.base) & OFFSET_MASK;
			if (c.len >= gap) begin
				pages = (c.len - gap) >> PAGE_SHIFT;
				frame = FRAME_W'((c.base + gap) >> PAGE_SHIFT);
				room = STACK_DEPTH - free_pages;
				n = pages;
				if (n > room) begin
					n = room;
					r.status = STATUS_FULL;
				end
				for (int unsigned i = 0; i < n; i++) begin
					frame_stack[free_pages] = frame;
					free_pages++;
					frame++;
				end
				r.pages_pushed = OUT_CNT_W'(n);
			end
		end
		r.free_count = OUT_CNT_W'(free_pages);
		return r;
	endfunction

	function automatic void compare_result(input string tag, input pfsa_result_t want,
		input pfsa_result_t act);
		if (act.page_addr !== want.page_addr) begin
			$error("%s page_addr: expected %h, got %h", tag, want.page_addr, act.page_addr);
			fail_count++;
		end
		if (act.status !== want.status) begin
			$error("%s status: expected %0d, got %0d", tag, want.status, act.status);
			fail_count++;
		end
		if (act.pages_pushed !== want.pages_pushed) begin
			$error("%s pages_pushed: expected %0d, got %0d", tag, want.pages_pushed,
				act.pages_pushed);
			fail_count++;
		end
		if (act.free_count !== want.free_count) begin
			$error("%s free_count: expected %0d, got %0d", tag, want.free_count,
				act.free_count);
			fail_count++;
		end
	endfunction

	// entered just after a falling edge, leaves just after the falling edge past the transfer
	task automatic send_cmd(input pfsa_cmd_t c, input logic typed, input pfsa_result_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_if.valid = 1'b0;
			@(negedge clk);
		end
		cmd_if.valid = 1'b1;
		cmd_if.kind = c.kind;
		cmd_if.region_base = c.base;
		cmd_if.region_len = c.len;
		row_typed = typed;
		row_want = want;
		do @(posedge clk); while (!cmd_if.ready);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// result and command sides, sampled at the rising edge
	always @(posedge clk) begin
		if (res_if.valid && res_if.ready) begin
			got = '{res_if.page_addr, res_if.status, res_if.pages_pushed, res_if.free_count};
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: page_addr %h status %0d",
					got.page_addr, got.status);
				fail_count++;
			end else begin
				head = pending_results.pop_front();
				compare_result("predicted", head.pred, got);
				if (head.typed)
					compare_result("table", head.want, got);
			end
		end
		if (cmd_if.valid && cmd_if.ready) begin
			pred_now = next_frame_result('{cmd_if.kind, cmd_if.region_base,
				cmd_if.region_len});
			pending_results.push_back('{pred_now, row_typed, row_want});
			if (cmd_if.kind == KIND_ALLOC) begin
				n_alloc++;
				if (pred_now.status == STATUS_EMPTY)
					n_empty++;
			end else begin
				n_free++;
				if (pred_now.status == STATUS_FULL)
					n_full++;
			end
		end
	end

	// receiver
	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				res_if.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				res_if.ready = ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("no transfer for %0d cycles", STALL_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// stimulus
	initial begin
		pfsa_cmd_t c;
		noise_t pick;
		logic [ADDR_W-1:0] gap;
		int burst;
		int sent;
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.kind = KIND_FREE;
		cmd_if.region_base = '0;
		cmd_if.region_len = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		src_idle_pct = 14;
		snk_idle_pct = 46;
		foreach (dir_tbl[i])
			send_cmd(dir_tbl[i].cmd, dir_tbl[i].typed, dir_tbl[i].want);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 14;
					snk_idle_pct = 46;
				end
				1: begin
					src_idle_pct = 46;
					snk_idle_pct = 14;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
					hold_pending = 1'b1;
				end
			endcase
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(99) < 85) begin
					// allocate burst, then a free of up to 24 pages; at <= 512 slots left, 40% are of any length
					burst = $urandom_range(1, 24);
					for (int j = 0; j < burst; j++) begin
						c = '{KIND_ALLOC, $urandom(), $urandom()};
						send_cmd(c, 1'b0, '0);
					end
					c.kind = KIND_FREE;
					c.base = $urandom();
					if ($urandom_range(99) < 40 && (STACK_DEPTH - free_pages) <= 512)
						c.len = $urandom();
					else
						c.len = (32'($urandom_range(0, 24)) << PAGE_SHIFT)
							| 32'($urandom_range(0, PAGE_BYTES - 1));
					send_cmd(c, 1'b0, '0);
					sent += burst + 1;
				end else begin
					pick = noise_t'($urandom_range(3));
					c = '{KIND_FREE, $urandom(), $urandom()};
					case (pick)
						NOISE_ALLOC: c.kind = KIND_ALLOC;
						NOISE_SHORT: begin
							c.base = (c.base & ~OFFSET_MASK)
								| 32'($urandom_range(1, PAGE_BYTES - 1));
							gap = (32'h0 - c.base) & OFFSET_MASK;
							c.len = 32'($urandom_range(0, gap - 1));
						end
						NOISE_NO_PAGE: begin
							gap = (32'h0 - c.base) & OFFSET_MASK;
							c.len = gap + 32'($urandom_range(0, PAGE_BYTES - 1));
						end
						default: begin
							c.base = c.base & ~OFFSET_MASK;
							c.len = PAGE_BYTES;
						end
					endcase
					send_cmd(c, 1'b0, '0);
					sent++;
				end
			end
			if (phase == 0) begin
				// sender goes quiet until the block has drained
				cmd_if.valid = 1'b0;
				while (pending_results.size() != 0) @(negedge clk);
			end
		end
		cmd_if.valid = 1'b0;

		while (pending_results.size() != 0) @(negedge clk);
		repeat (END_CYCLES) @(posedge clk);
		$display("%0d commands: %0d allocates, %0d of them on an empty stack", n_alloc + n_free,
			n_alloc, n_empty);
		$display("%0d frees, %0d of them stopped by a full stack", n_free, n_full);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/pfsa_pkg.sv
rtl/core/pfsa_if.sv
rtl/core/pfsa_stack_ram.sv
rtl/core/pfsa_seq.sv
rtl/core/page_frame_stack_allocator_top.sv
sim/tb_top.sv
